/* rtl/sjfs_pkg.sv */
// Shared types and constants for the shortest-job-first scheduler.
`default_nettype none

package sjfs_pkg;

    localparam int ID_W   = 8;
    localparam int ARR_W  = 16;
    localparam int BST_W  = 16;
    localparam int TIME_W = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Running candidate carried along the cell chain during one scan pass.
    typedef struct packed {
        logic             found;    // an eligible job has been seen
        logic [BST_W-1:0] burst;
        logic [ARR_W-1:0] arrival;
        logic [ID_W-1:0]  job_id;
        logic             pend;     // an unfinished job has been seen
        logic [ARR_W-1:0] min_arr;  // earliest arrival among unfinished jobs
    } sjfs_cand_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE
    } sjfs_state_t;

endpackage

`default_nettype wire

/* rtl/sjfs_cell.sv */
// One job slot of the scheduler chain: stores a job and updates the passing candidate.
`default_nettype none

module sjfs_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDXW     = 6,
    parameter int CNTW     = 7
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           wr_en,
    input  wire  [IDXW-1:0]               wr_idx,
    input  wire  [sjfs_pkg::ID_W-1:0]     wr_id,
    input  wire  [sjfs_pkg::ARR_W-1:0]    wr_arr,
    input  wire  [sjfs_pkg::BST_W-1:0]    wr_burst,
    input  wire  [CNTW-1:0]               job_count,
    input  wire  [sjfs_pkg::TIME_W-1:0]   sched_clock,
    input  wire                           set_done,
    input  wire  [IDXW-1:0]               done_idx,
    input  wire                           clr_done,
    input  wire                           pass_in,
    input  wire  sjfs_pkg::sjfs_cand_t    cand_in,
    input  wire  [IDXW-1:0]               idx_in,
    output logic                          pass_out,
    output sjfs_pkg::sjfs_cand_t          cand_out,
    output logic [IDXW-1:0]               idx_out
);
    import sjfs_pkg::*;

    localparam logic [IDXW-1:0] MY_IDX = IDXW'(CELL_IDX);
    localparam logic [CNTW-1:0] MY_CNT = CNTW'(CELL_IDX);

    logic [ID_W-1:0]  id_reg;
    logic [ARR_W-1:0] arr_reg;
    logic [BST_W-1:0] burst_reg;
    logic             done_reg;
    logic             done_next;

    logic             pass_reg;
    sjfs_cand_t       cand_reg;
    sjfs_cand_t       cand_next;
    logic [IDXW-1:0]  idx_reg;
    logic [IDXW-1:0]  idx_next;

    logic occupied;
    logic pending;
    logic eligible;
    logic better;

    assign occupied = (MY_CNT < job_count);
    assign pending  = occupied && !done_reg;
    assign eligible = pending && ({{(TIME_W-ARR_W){1'b0}}, arr_reg} <= sched_clock);
    assign better   = !cand_in.found || (burst_reg < cand_in.burst) ||
                      ((burst_reg == cand_in.burst) && (arr_reg < cand_in.arrival));

    // Hold job payload; written once per load.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            id_reg    <= wr_id;
            arr_reg   <= wr_arr;
            burst_reg <= wr_burst;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (wr_en && (wr_idx == MY_IDX))
            done_next = 1'b0;
        if (set_done && (done_idx == MY_IDX))
            done_next = 1'b1;
        if (clr_done)
            done_next = 1'b0;
    end

    // Update the candidate; ties keep the lower index already in the packet.
    always_comb
    begin
        cand_next = cand_in;
        idx_next  = idx_in;
        if (eligible && better)
        begin
            cand_next.found   = 1'b1;
            cand_next.burst   = burst_reg;
            cand_next.arrival = arr_reg;
            cand_next.job_id  = id_reg;
            idx_next          = MY_IDX;
        end
        if (pending && (!cand_in.pend || (arr_reg < cand_in.min_arr)))
        begin
            cand_next.pend    = 1'b1;
            cand_next.min_arr = arr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            pass_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            pass_reg <= pass_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        idx_reg  <= idx_next;
    end

    assign pass_out = pass_reg;
    assign cand_out = cand_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

/* rtl/sjf_nonpreemptive_scheduler_unit.sv */
// Top level of the non-preemptive shortest-job-first scheduler.
// Input channel (in_valid / in_stall): one job per transaction with job_id,
//   arrival and burst. Jobs load one per cycle into a row of MAX_JOBS cells;
//   jobs beyond MAX_JOBS are dropped. A transaction with last_job set stores
//   its job (if room) and starts scheduling the whole set.
// Output channel (out_valid / out_stall): one transaction per stored job, in
//   run order, with run_id, start_time, wait_time, turnaround and last_run.
// Each pick is one scan pass: a candidate packet walks the cell chain, one
//   cell per cycle, from the launch register to the pick register; when no job has
//   arrived yet the clock jumps to the earliest pending arrival and one more
//   pass follows. A set of N jobs thus takes about N to 2N passes.
// in_stall is high from the last_job transaction until the final result has
//   been captured in the output register; the next set may load while that
//   result still waits for the receiver.
// While out_stall is high the output register holds its transaction; the
//   next pass still runs and its pick waits until the register frees.
// Reset clears the job count, done flags, clock and all valid state.
`default_nettype none

module sjf_nonpreemptive_scheduler_unit #(
    parameter int MAX_JOBS = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire  [sjfs_pkg::ID_W-1:0]    job_id,
    input  wire  [sjfs_pkg::ARR_W-1:0]   arrival,
    input  wire  [sjfs_pkg::BST_W-1:0]   burst,
    input  wire                          last_job,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [sjfs_pkg::ID_W-1:0]    run_id,
    output logic [sjfs_pkg::TIME_W-1:0]  start_time,
    output logic [sjfs_pkg::TIME_W-1:0]  wait_time,
    output logic [sjfs_pkg::TIME_W-1:0]  turnaround,
    output logic                         last_run
);
    import sjfs_pkg::*;

    localparam int IDXW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNTW = $clog2(MAX_JOBS + 1);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_JOBS);

    sjfs_state_t       state_reg;
    sjfs_state_t       state_next;
    logic [CNTW-1:0]   count_reg;
    logic [CNTW-1:0]   count_next;
    logic [CNTW-1:0]   emit_reg;
    logic [CNTW-1:0]   emit_next;
    logic [TIME_W-1:0] clock_reg;
    logic [TIME_W-1:0] clock_next;
    sjfs_cand_t        pick_reg;
    logic [IDXW-1:0]   pick_idx_reg;
    logic              launch_reg;
    logic              launch_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ID_W-1:0]   run_id_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] wait_reg;
    logic [TIME_W-1:0] turn_reg;
    logic              last_reg;

    // Chain wiring: stage 0 is the packet injected by the controller.
    logic              pass_w [0:MAX_JOBS];
    sjfs_cand_t        cand_w [0:MAX_JOBS];
    logic [IDXW-1:0]   idx_w  [0:MAX_JOBS];

    logic              in_fire;
    logic              wr_en;
    logic              set_done;
    logic              clr_done;
    logic              out_load;
    logic              out_free;
    logic              final_pick;

    logic [TIME_W:0]   sum_w;
    logic [TIME_W-1:0] finish_w;
    logic [TIME_W-1:0] pick_arr_w;

    assign in_stall = (state_reg != ST_LOAD);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign pick_arr_w = {{(TIME_W-ARR_W){1'b0}}, pick_reg.arrival};
    assign sum_w      = {1'b0, clock_reg} + {{(TIME_W+1-BST_W){1'b0}}, pick_reg.burst};
    assign finish_w   = sum_w[TIME_W] ? TIME_MAX : sum_w[TIME_W-1:0];
    assign final_pick = (CNTW'(emit_reg + 1'b1) == count_reg);

    // Launch from a register so the first cell sees the updated count, clock
    // and done flags.
    assign pass_w[0] = launch_reg;
    assign cand_w[0] = '0;
    assign idx_w[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_JOBS; g++)
        begin : g_cell
            sjfs_cell #(
                .CELL_IDX (g),
                .IDXW     (IDXW),
                .CNTW     (CNTW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .wr_en       (wr_en),
                .wr_idx      (count_reg[IDXW-1:0]),
                .wr_id       (job_id),
                .wr_arr      (arrival),
                .wr_burst    (burst),
                .job_count   (count_reg),
                .sched_clock (clock_reg),
                .set_done    (set_done),
                .done_idx    (pick_idx_reg),
                .clr_done    (clr_done),
                .pass_in     (pass_w[g]),
                .cand_in     (cand_w[g]),
                .idx_in      (idx_w[g]),
                .pass_out    (pass_w[g+1]),
                .cand_out    (cand_w[g+1]),
                .idx_out     (idx_w[g+1])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last_job)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (pass_w[MAX_JOBS])
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!pick_reg.found)
                    state_next = ST_SCAN;
                else if (out_free)
                    state_next = final_pick ? ST_LOAD : ST_SCAN;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Control outputs and bookkeeping.
    always_comb
    begin
        wr_en       = 1'b0;
        launch_next = 1'b0;
        set_done    = 1'b0;
        clr_done    = 1'b0;
        out_load    = 1'b0;
        count_next  = count_reg;
        emit_next   = emit_reg;
        clock_next  = clock_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        wr_en      = 1'b1;
                        count_next = CNTW'(count_reg + 1'b1);
                    end
                    launch_next = last_job;
                end
            end
            ST_SCAN:
            begin
            end
            ST_DECIDE:
            begin
                if (!pick_reg.found)
                begin
                    // Nothing has arrived: jump the clock and rescan.
                    clock_next  = {{(TIME_W-ARR_W){1'b0}}, pick_reg.min_arr};
                    launch_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    if (final_pick)
                    begin
                        // Set finished: drop all bookkeeping for the next set.
                        clr_done   = 1'b1;
                        count_next = '0;
                        emit_next  = '0;
                        clock_next = '0;
                    end
                    else
                    begin
                        set_done    = 1'b1;
                        emit_next   = CNTW'(emit_reg + 1'b1);
                        clock_next  = finish_w;
                        launch_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            emit_reg      <= '0;
            clock_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            clock_reg     <= clock_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the chain tail at the end of each pass.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && pass_w[MAX_JOBS])
        begin
            pick_reg     <= cand_w[MAX_JOBS];
            pick_idx_reg <= idx_w[MAX_JOBS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            run_id_reg <= pick_reg.job_id;
            start_reg  <= clock_reg;
            wait_reg   <= clock_reg - pick_arr_w;
            turn_reg   <= finish_w - pick_arr_w;
            last_reg   <= final_pick;
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_id     = run_id_reg;
    assign start_time = start_reg;
    assign wait_time  = wait_reg;
    assign turnaround = turn_reg;
    assign last_run   = last_reg;

endmodule

`default_nettype wire

/* dv/sjf_nonpreemptive_scheduler_unit_test.sv */
// Self-checking testbench for the non-preemptive shortest-job-first scheduler.
`timescale 1ns / 1ps

// One scheduled job as it leaves the block.
typedef struct packed {
    logic [sjfs_pkg::ID_W-1:0]   rid;
    logic [sjfs_pkg::TIME_W-1:0] start;
    logic [sjfs_pkg::TIME_W-1:0] waited;
    logic [sjfs_pkg::TIME_W-1:0] turn;
    logic                        fin;
} run_rec_t;

// Holds the job set being loaded and the run order it must produce.
class run_order_board;
    logic [sjfs_pkg::ID_W-1:0]  ids  [256];
    logic [sjfs_pkg::ARR_W-1:0] arrs [256];
    logic [sjfs_pkg::BST_W-1:0] bsts [256];
    int unsigned stored;
    int unsigned capacity;
    int unsigned mismatch_count;
    run_rec_t    expected_runs [$];

    function new(int unsigned cap);
        capacity       = cap;
        stored         = 0;
        mismatch_count = 0;
    endfunction

    function int unsigned pending();
        return expected_runs.size();
    endfunction

    function void report(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Store the job if there is room; a last mark schedules the stored set.
    function void note_job(logic [sjfs_pkg::ID_W-1:0] id, logic [sjfs_pkg::ARR_W-1:0] arr,
                           logic [sjfs_pkg::BST_W-1:0] bst, logic last);
        if (stored < capacity)
        begin
            ids[stored]  = id;
            arrs[stored] = arr;
            bsts[stored] = bst;
            stored++;
        end
        if (last)
        begin
            plan_schedule();
            stored = 0;
        end
    endfunction

    function void plan_schedule();
        bit          done [256];
        int unsigned clock_now;
        int unsigned finish;
        int unsigned emitted;
        int unsigned span;
        int          best;
        run_rec_t    rec;
        foreach (done[i])
            done[i] = 1'b0;
        clock_now = 0;
        emitted   = 0;
        while (emitted < stored)
        begin
            best = -1;
            for (int i = 0; i < stored; i++)
            begin
                if (done[i] || 32'(arrs[i]) > clock_now)
                    continue;
                if (best < 0 || bsts[i] < bsts[best] ||
                    (bsts[i] == bsts[best] && arrs[i] < arrs[best]))
                    best = i;
            end
            if (best < 0)
            begin
                // Nothing has arrived: jump to the earliest pending arrival.
                clock_now = 32'(sjfs_pkg::TIME_MAX);
                for (int i = 0; i < stored; i++)
                    if (!done[i] && 32'(arrs[i]) < clock_now)
                        clock_now = 32'(arrs[i]);
                continue;
            end
            finish = clock_now + 32'(bsts[best]);
            if (finish > 32'(sjfs_pkg::TIME_MAX))
                finish = 32'(sjfs_pkg::TIME_MAX);
            rec.rid    = ids[best];
            rec.start  = clock_now[sjfs_pkg::TIME_W-1:0];
            span       = clock_now - 32'(arrs[best]);
            rec.waited = span[sjfs_pkg::TIME_W-1:0];
            span       = finish - 32'(arrs[best]);
            rec.turn   = span[sjfs_pkg::TIME_W-1:0];
            rec.fin    = (emitted + 1 == stored);
            expected_runs.push_back(rec);
            clock_now  = finish;
            done[best] = 1'b1;
            emitted++;
        end
    endfunction

    function void check_run(run_rec_t got);
        run_rec_t want;
        if (expected_runs.size() == 0)
        begin
            report($sformatf("unexpected run id=%0d start=%0d wait=%0d turn=%0d last=%0d",
                             got.rid, got.start, got.waited, got.turn, got.fin));
            return;
        end
        want = expected_runs.pop_front();
        if (got.rid !== want.rid || got.start !== want.start || got.waited !== want.waited ||
            got.turn !== want.turn || got.fin !== want.fin)
            report($sformatf({"expected id=%0d start=%0d wait=%0d turn=%0d last=%0d, ",
                              "got id=%0d start=%0d wait=%0d turn=%0d last=%0d"},
                             want.rid, want.start, want.waited, want.turn, want.fin,
                             got.rid, got.start, got.waited, got.turn, got.fin));
    endfunction
endclass

module sjf_nonpreemptive_scheduler_unit_test;
    import sjfs_pkg::*;

    localparam int MAX_JOBS    = 64;
    localparam int RAND_ITEMS  = 360;
    // Margin after the drain: room for two scan passes plus gaps.
    localparam int DRAIN_WAIT  = 2 * (MAX_JOBS + 2) + 32;
    localparam int CYCLE_LIMIT = 600000;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic [ID_W-1:0]   job_id     = '0;
    logic [ARR_W-1:0]  arrival    = '0;
    logic [BST_W-1:0]  burst      = '0;
    logic              last_job   = 1'b0;
    logic              out_stall  = 1'b0;
    wire               in_stall;
    wire               out_valid;
    wire  [ID_W-1:0]   run_id;
    wire  [TIME_W-1:0] start_time;
    wire  [TIME_W-1:0] wait_time;
    wire  [TIME_W-1:0] turnaround;
    wire               last_run;

    // Per-set switches that turn off idling on one side for a stretch.
    bit in_quiet  = 1'b0;
    bit out_quiet = 1'b0;
    int unsigned jobs_sent = 0;

    run_order_board board;

    sjf_nonpreemptive_scheduler_unit #(
        .MAX_JOBS(MAX_JOBS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .job_id     (job_id),
        .arrival    (arrival),
        .burst      (burst),
        .last_job   (last_job),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .run_id     (run_id),
        .start_time (start_time),
        .wait_time  (wait_time),
        .turnaround (turnaround),
        .last_run   (last_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run: a hang in either channel ends here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Offer one job transaction and hold it until the block takes it.
    // Keep in_valid high across back-to-back jobs so it never drops and
    // rises within one time step.
    task automatic send_job(input logic [ID_W-1:0] id, input logic [ARR_W-1:0] arr,
                            input logic [BST_W-1:0] bst, input logic last);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        job_id   <= id;
        arrival  <= arr;
        burst    <= bst;
        last_job <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        // Accepted at this edge; let the board predict right away.
        board.note_job(id, arr, bst, last);
        jobs_sent++;
    endtask

    // Send a set of random jobs, the final one marked last.
    // Mode 0 crowds arrivals and bursts so ties and contention are common,
    // mode 1 spans the full field range, mode 2 sits in between.
    task automatic send_set(input int unsigned size);
        int unsigned mode;
        logic [ARR_W-1:0] arr;
        logic [BST_W-1:0] bst;
        mode      = $urandom_range(0, 2);
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < size; j++)
        begin
            case (mode)
                0:
                begin
                    arr = ARR_W'($urandom_range(0, 15));
                    bst = BST_W'($urandom_range(0, 7));
                end
                1:
                begin
                    arr = ARR_W'($urandom);
                    bst = BST_W'($urandom);
                end
                default:
                begin
                    arr = ARR_W'($urandom_range(0, 400));
                    bst = BST_W'($urandom_range(0, 120));
                end
            endcase
            send_job(ID_W'($urandom), arr, bst, j == size - 1);
        end
    endtask

    // Result side: draw a stall for every transaction, then take the next
    // valid result and hand it to the board.
    initial
    begin
        int unsigned hold;
        run_rec_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = out_quiet ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got.rid    = run_id;
            got.start  = start_time;
            got.waited = wait_time;
            got.turn   = turnaround;
            got.fin    = last_run;
            board.check_run(got);
        end
    end

    initial
    begin
        int unsigned set_no;
        int unsigned size;
        board = new(MAX_JOBS);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single job with every field at zero.
        send_job(8'd0, 16'd0, 16'd0, 1'b1);
        // Single job at the top of every field: clock idles up to the arrival.
        send_job(8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        // Ties: equal bursts split by arrival, then by load order; a short job
        // arriving after the others finish makes the clock jump to its arrival.
        send_job(8'd10, 16'd5, 16'd3, 1'b0);
        send_job(8'd11, 16'd0, 16'd7, 1'b0);
        send_job(8'd12, 16'd2, 16'd3, 1'b0);
        send_job(8'd13, 16'd2, 16'd3, 1'b0);
        send_job(8'd14, 16'd40, 16'd1, 1'b0);
        send_job(8'd15, 16'd0, 16'd7, 1'b1);
        // Nothing ready at time zero, and a long first job that the later arrivals wait behind.
        send_job(8'd20, 16'd100, 16'd5, 1'b0);
        send_job(8'd21, 16'd100, 16'd5, 1'b0);
        send_job(8'd22, 16'd300, 16'd0, 1'b0);
        send_job(8'd23, 16'd50, 16'hFFFF, 1'b1);

        // Random sets: mostly small, a full store, and two that overflow it
        // so the marked job is dropped yet still starts the schedule.
        set_no    = 0;
        jobs_sent = 0;
        while (jobs_sent < RAND_ITEMS)
        begin
            if (set_no == 4 || set_no == 20)
                size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 6);
            else if (set_no == 12)
                size = MAX_JOBS;
            else
                size = $urandom_range(1, 12);
            send_set(size);
            set_no++;
        end
        in_valid <= 1'b0;

        // Drain every expected run, then watch for strays.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
